@@ rtl/core/dst_pkg.sv @@
// Shared types, codes and the keyword table of the date string tokenizer.
package dst_pkg;

	localparam int MAX_WORD_LEN_DEF = 10;
	localparam int KW_COUNT = 88;
	localparam int KW_IDX_W = $clog2(KW_COUNT);
	localparam int OUTQ_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM,
		MODE_FIN
	} mode_t;

	typedef enum logic [3:0] {
		K_FILLER,
		K_AMPM,
		K_MONTH,
		K_WDAY,
		K_ZONE,
		K_NUMBER,
		K_DELIM,
		K_UNKNOWN,
		K_END
	} kind_t;

	typedef struct packed {
		logic               last;
		logic [31:0]        nv;
		logic [7:0]         dc;
		logic signed [8:0]  value;
		kind_t              kind;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} push_t;

	// Keyword text is right-justified: the last letter sits in the low byte.
	typedef struct packed {
		logic [71:0]       txt;
		logic [3:0]        len;
		kind_t             kind;
		logic signed [8:0] val;
	} kw_t;

	function automatic tok_t mk_tok(kind_t kind, logic signed [8:0] value,
			logic [7:0] dc, logic [31:0] nv);
		tok_t t;
		t.last  = 1'b0;
		t.kind  = kind;
		t.value = value;
		t.dc    = dc;
		t.nv    = nv;
		return t;
	endfunction

	function automatic kw_t kw_entry(logic [KW_IDX_W-1:0] k);
		kw_t e;
		case (k)
			7'd0:  e = '{"t", 4'd1, K_FILLER, 9'sd0};
			7'd1:  e = '{"th", 4'd2, K_FILLER, 9'sd0};
			7'd2:  e = '{"nth", 4'd3, K_FILLER, 9'sd0};
			7'd3:  e = '{"st", 4'd2, K_FILLER, 9'sd0};
			7'd4:  e = '{"nd", 4'd2, K_FILLER, 9'sd0};
			7'd5:  e = '{"am", 4'd2, K_AMPM, 9'sd0};
			7'd6:  e = '{"pm", 4'd2, K_AMPM, 9'sd1};
			7'd7:  e = '{"january", 4'd7, K_MONTH, 9'sd0};
			7'd8:  e = '{"february", 4'd8, K_MONTH, 9'sd1};
			7'd9:  e = '{"march", 4'd5, K_MONTH, 9'sd2};
			7'd10: e = '{"april", 4'd5, K_MONTH, 9'sd3};
			7'd11: e = '{"may", 4'd3, K_MONTH, 9'sd4};
			7'd12: e = '{"june", 4'd4, K_MONTH, 9'sd5};
			7'd13: e = '{"july", 4'd4, K_MONTH, 9'sd6};
			7'd14: e = '{"august", 4'd6, K_MONTH, 9'sd7};
			7'd15: e = '{"september", 4'd9, K_MONTH, 9'sd8};
			7'd16: e = '{"october", 4'd7, K_MONTH, 9'sd9};
			7'd17: e = '{"november", 4'd8, K_MONTH, 9'sd10};
			7'd18: e = '{"december", 4'd8, K_MONTH, 9'sd11};
			7'd19: e = '{"jan", 4'd3, K_MONTH, 9'sd0};
			7'd20: e = '{"feb", 4'd3, K_MONTH, 9'sd1};
			7'd21: e = '{"mar", 4'd3, K_MONTH, 9'sd2};
			7'd22: e = '{"apr", 4'd3, K_MONTH, 9'sd3};
			7'd23: e = '{"jun", 4'd3, K_MONTH, 9'sd5};
			7'd24: e = '{"jul", 4'd3, K_MONTH, 9'sd6};
			7'd25: e = '{"aug", 4'd3, K_MONTH, 9'sd7};
			7'd26: e = '{"sep", 4'd3, K_MONTH, 9'sd8};
			7'd27: e = '{"oct", 4'd3, K_MONTH, 9'sd9};
			7'd28: e = '{"nov", 4'd3, K_MONTH, 9'sd10};
			7'd29: e = '{"dec", 4'd3, K_MONTH, 9'sd11};
			7'd30: e = '{"sunday", 4'd6, K_WDAY, 9'sd0};
			7'd31: e = '{"monday", 4'd6, K_WDAY, 9'sd1};
			7'd32: e = '{"tuesday", 4'd7, K_WDAY, 9'sd2};
			7'd33: e = '{"wednesday", 4'd9, K_WDAY, 9'sd3};
			7'd34: e = '{"thursday", 4'd8, K_WDAY, 9'sd4};
			7'd35: e = '{"friday", 4'd6, K_WDAY, 9'sd5};
			7'd36: e = '{"saturday", 4'd8, K_WDAY, 9'sd6};
			7'd37: e = '{"sun", 4'd3, K_WDAY, 9'sd0};
			7'd38: e = '{"mon", 4'd3, K_WDAY, 9'sd1};
			7'd39: e = '{"tue", 4'd3, K_WDAY, 9'sd2};
			7'd40: e = '{"wed", 4'd3, K_WDAY, 9'sd3};
			7'd41: e = '{"thu", 4'd3, K_WDAY, 9'sd4};
			7'd42: e = '{"fri", 4'd3, K_WDAY, 9'sd5};
			7'd43: e = '{"sat", 4'd3, K_WDAY, 9'sd6};
			7'd44: e = '{"idlw", 4'd4, K_ZONE, -9'sd12};
			7'd45: e = '{"nt", 4'd2, K_ZONE, -9'sd11};
			7'd46: e = '{"cat", 4'd3, K_ZONE, -9'sd10};
			7'd47: e = '{"hst", 4'd3, K_ZONE, -9'sd10};
			7'd48: e = '{"hdt", 4'd3, K_ZONE, -9'sd9};
			7'd49: e = '{"yst", 4'd3, K_ZONE, -9'sd9};
			7'd50: e = '{"ydt", 4'd3, K_ZONE, -9'sd8};
			7'd51: e = '{"pst", 4'd3, K_ZONE, -9'sd8};
			7'd52: e = '{"pdt", 4'd3, K_ZONE, -9'sd7};
			7'd53: e = '{"mst", 4'd3, K_ZONE, -9'sd7};
			7'd54: e = '{"mdt", 4'd3, K_ZONE, -9'sd6};
			7'd55: e = '{"cst", 4'd3, K_ZONE, -9'sd6};
			7'd56: e = '{"cdt", 4'd3, K_ZONE, -9'sd5};
			7'd57: e = '{"est", 4'd3, K_ZONE, -9'sd5};
			7'd58: e = '{"edt", 4'd3, K_ZONE, -9'sd4};
			7'd59: e = '{"ast", 4'd3, K_ZONE, -9'sd3};
			7'd60: e = '{"adt", 4'd3, K_ZONE, -9'sd2};
			7'd61: e = '{"wat", 4'd3, K_ZONE, -9'sd1};
			7'd62: e = '{"gmt", 4'd3, K_ZONE, 9'sd0};
			7'd63: e = '{"utc", 4'd3, K_ZONE, 9'sd0};
			7'd64: e = '{"z", 4'd1, K_ZONE, 9'sd0};
			7'd65: e = '{"wet", 4'd3, K_ZONE, 9'sd0};
			7'd66: e = '{"bst", 4'd3, K_ZONE, 9'sd1};
			7'd67: e = '{"cet", 4'd3, K_ZONE, 9'sd1};
			7'd68: e = '{"met", 4'd3, K_ZONE, 9'sd1};
			7'd69: e = '{"mewt", 4'd4, K_ZONE, 9'sd1};
			7'd70: e = '{"mest", 4'd4, K_ZONE, 9'sd2};
			7'd71: e = '{"cest", 4'd4, K_ZONE, 9'sd2};
			7'd72: e = '{"mesz", 4'd4, K_ZONE, 9'sd2};
			7'd73: e = '{"fwt", 4'd3, K_ZONE, 9'sd1};
			7'd74: e = '{"fst", 4'd3, K_ZONE, 9'sd2};
			7'd75: e = '{"eet", 4'd3, K_ZONE, 9'sd2};
			7'd76: e = '{"eest", 4'd4, K_ZONE, 9'sd3};
			7'd77: e = '{"wast", 4'd4, K_ZONE, 9'sd7};
			7'd78: e = '{"wadt", 4'd4, K_ZONE, 9'sd8};
			7'd79: e = '{"cct", 4'd3, K_ZONE, 9'sd8};
			7'd80: e = '{"jst", 4'd3, K_ZONE, 9'sd9};
			7'd81: e = '{"east", 4'd4, K_ZONE, 9'sd10};
			7'd82: e = '{"eadt", 4'd4, K_ZONE, 9'sd11};
			7'd83: e = '{"gst", 4'd3, K_ZONE, 9'sd10};
			7'd84: e = '{"nzt", 4'd3, K_ZONE, 9'sd12};
			7'd85: e = '{"nzst", 4'd4, K_ZONE, 9'sd12};
			7'd86: e = '{"nzdt", 4'd4, K_ZONE, 9'sd13};
			7'd87: e = '{"idle", 4'd4, K_ZONE, 9'sd12};
			default: e = '{72'd0, 4'd0, K_FILLER, 9'sd0};
		endcase
		return e;
	endfunction

endpackage

@@ rtl/core/dst_lexer.sv @@
// Lexer state and token generation for one character per cycle while valid is high.
module dst_lexer import dst_pkg::*; #(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [7:0] char_code,
	input  logic       is_terminator,
	output push_t      push
);

	localparam int WLW = $clog2(MAX_WORD_LEN + 2);

	mode_t                 mode_q, mode_n;
	logic [WLW-1:0]        word_len_q, word_len_n;
	logic [KW_COUNT-1:0]   alive_q, alive_n;
	logic                  hit_valid_q, hit_valid_n;
	kind_t                 hit_kind_q, hit_kind_n;
	logic signed [8:0]     hit_val_q, hit_val_n;
	logic [7:0]            dc_q, dc_n;
	logic [31:0]           acc_q, acc_n;

	logic       is_upper, is_lower, is_digit, is_delim, start_word;
	logic [7:0] lc;
	logic [WLW-1:0] pos;
	logic [KW_COUNT-1:0] base;
	logic [35:0] prod;
	logic [31:0] acc_base;
	logic [7:0]  dc_base;
	logic        fl_valid, fl_stop;
	tok_t        fl_tok;
	push_t       p;

	always_comb begin
		kw_t        e;
		logic [3:0] idx;
		is_upper = char_code >= 8'h41 && char_code <= 8'h5A;
		is_lower = char_code >= 8'h61 && char_code <= 8'h7A;
		is_digit = char_code >= 8'h30 && char_code <= 8'h39;
		is_delim = char_code == 8'h20 || char_code == 8'h2C || char_code == 8'h2F ||
			char_code == 8'h3A || char_code == 8'h2E || char_code == 8'h2B ||
			char_code == 8'h2D;
		lc = is_upper ? char_code + 8'd32 : char_code;
		start_word = mode_q != MODE_WORD;
		pos  = start_word ? '0 : word_len_q;
		base = start_word ? '1 : alive_q;
		alive_n = '0;
		hit_valid_n = 1'b0;
		hit_kind_n  = K_FILLER;
		hit_val_n   = 9'sd0;
		// Narrow the candidate set by one letter; the first survivor whose
		// length equals the letters seen so far is the match.
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			e = kw_entry(k[KW_IDX_W-1:0]);
			idx = e.len - 4'd1 - pos[3:0];
			alive_n[k] = base[k] && (int'(pos) < int'(e.len)) &&
				(e.txt[8*idx +: 8] == lc);
			if (alive_n[k] && int'(e.len) == int'(pos) + 1) begin
				hit_valid_n = 1'b1;
				hit_kind_n  = e.kind;
				hit_val_n   = e.val;
			end
		end
	end

	// Saturating decimal accumulate; a carry above bit 31 means overflow.
	always_comb begin
		acc_base = (mode_q == MODE_NUM) ? acc_q : 32'd0;
		dc_base  = (mode_q == MODE_NUM) ? dc_q : 8'd0;
		prod = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
			{32'd0, char_code[3:0]};
	end

	// Flush of the pending run.
	always_comb begin
		fl_valid = 1'b0;
		fl_stop  = 1'b0;
		fl_tok   = mk_tok(K_END, 9'sd0, 8'd0, 32'd0);
		case (mode_q)
			MODE_WORD: begin
				fl_valid = 1'b1;
				if (hit_valid_q) begin
					fl_tok = mk_tok(hit_kind_q, hit_val_q, 8'd0, 32'd0);
				end else begin
					fl_tok  = mk_tok(K_UNKNOWN, 9'sd0, 8'd0, 32'd0);
					fl_stop = 1'b1;
				end
			end
			MODE_NUM: begin
				fl_valid = 1'b1;
				fl_tok   = mk_tok(K_NUMBER, 9'sd0, dc_q, acc_q);
			end
			default: begin
				fl_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		tok_t second;
		logic add2;
		mode_n     = mode_q;
		word_len_n = word_len_q;
		dc_n       = dc_q;
		acc_n      = acc_q;
		second     = mk_tok(K_END, 9'sd0, 8'd0, 32'd0);
		add2       = 1'b0;
		p.n  = 2'd0;
		p.t0 = fl_tok;
		p.t1 = fl_tok;
		if (mode_q == MODE_FIN) begin
			if (is_terminator) mode_n = MODE_IDLE;
		end else if (is_terminator) begin
			add2   = !fl_stop;
			mode_n = MODE_IDLE;
		end else if (is_upper || is_lower) begin
			p.n = {1'b0, mode_q == MODE_NUM};
			mode_n = MODE_WORD;
			word_len_n = (int'(pos) <= MAX_WORD_LEN) ? pos + 1'b1 : pos;
		end else if (is_digit) begin
			p.n = {1'b0, mode_q == MODE_WORD};
			if (fl_stop) begin
				mode_n = MODE_FIN;
			end else begin
				mode_n = MODE_NUM;
				dc_n   = (dc_base == 8'd255) ? dc_base : dc_base + 8'd1;
				acc_n  = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
			end
		end else if (is_delim) begin
			second = mk_tok(K_DELIM, $signed({1'b0, char_code}), 8'd0, 32'd0);
			add2   = !fl_stop;
			mode_n = fl_stop ? MODE_FIN : MODE_IDLE;
		end else begin
			add2   = !fl_stop;
			mode_n = MODE_FIN;
		end
		if (mode_q != MODE_FIN && (is_terminator || !(is_upper || is_lower || is_digit))) begin
			p.n = {1'b0, fl_valid} + {1'b0, add2};
		end
		if (add2) begin
			if (fl_valid) p.t1 = second;
			else p.t0 = second;
		end
		if (p.n == 2'd2) p.t1.last = 1'b1;
		else p.t0.last = 1'b1;
		if (!valid) p.n = 2'd0;
	end

	assign push = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			word_len_q  <= '0;
			dc_q        <= 8'd0;
			acc_q       <= 32'd0;
			hit_valid_q <= 1'b0;
			alive_q     <= '0;
		end else if (valid) begin
			mode_q     <= mode_n;
			word_len_q <= word_len_n;
			dc_q       <= dc_n;
			acc_q      <= acc_n;
			if (mode_q != MODE_FIN && !is_terminator && (is_upper || is_lower)) begin
				alive_q     <= alive_n;
				hit_valid_q <= hit_valid_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid && mode_q != MODE_FIN && !is_terminator && (is_upper || is_lower)) begin
			hit_kind_q <= hit_kind_n;
			hit_val_q  <= hit_val_n;
		end
	end

endmodule

@@ rtl/core/dst_outq.sv @@
// Small result queue that takes up to two tokens a cycle and emits one while m_tready is high.
module dst_outq import dst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	output logic        m_tvalid,
	input  logic        m_tready,
	output tok_t        head
);

	localparam int PW = $clog2(OUTQ_DEPTH);

	tok_t            mem_q [OUTQ_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     count_q;
	logic            pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = count_q != '0;
	assign room     = int'(count_q) <= OUTQ_DEPTH - 2;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push.n);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + (PW+1)'(push.n) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.t0;
		if (push.n == 2'd2) mem_q[wr_q + PW'(1)] <= push.t1;
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= OUTQ_DEPTH) else $error("result queue overflow");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room) else $error("push without room");
	a_push_code: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3) else $error("bad push count");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd0 && !pop) |=> $stable(count_q))
		else $error("count moved while idle");
`endif

endmodule

@@ rtl/core/date_string_tokenizer.sv @@
// Top level of the date string tokenizer: input register, lexer and result queue.
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] character byte, tlast end of string
// m_axis    out  tdata token fields, tlast last token of one character
//
// One character is taken per cycle. It is registered, and the lexer then matches
// it against the keyword table and its run state and pushes zero, one or two
// tokens into a four-entry result queue. The queue emits one token per cycle
// while m_axis_tready is high, so a character with two tokens needs two output
// transfers; the input stalls only when fewer than two queue entries are free.
// Reset clears the lexer to idle and empties the queue; there is no clearing pass.
module date_string_tokenizer import dst_pkg::*; #(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // is_terminator
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] token_kind, [12:4] token_value, [20:13] digit_count,
	// [52:21] number_value, [55:53] zero
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast    // last_of_run
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       term_s1;
	logic       room;
	logic       process;
	push_t      push;
	tok_t       head;

	// The registered character is consumed only when the queue can take the
	// worst case of two tokens.
	assign process       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			term_s1 <= s_axis_tlast;
		end
	end

	dst_lexer #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_lexer (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (process),
		.char_code     (char_s1),
		.is_terminator (term_s1),
		.push          (push)
	);

	dst_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.head     (head)
	);

	assign m_axis_tdata = {3'b000, head.nv, head.dc, head.value, head.kind};
	assign m_axis_tlast = head.last;

endmodule
